// File: rtl/fdl_pkg.sv
package fdl_pkg;

    // fixed field widths
    localparam int OP_W    = 2;
    localparam int BPOS_W  = 10;
    localparam int DELAY_W = 26;
    localparam int ADV_W   = 10;

    // default configuration
    localparam int DEF_DEPTH       = 1024;
    localparam int DEF_SAMPLE_BITS = 24;
    localparam int DEF_FRAC_BITS   = 16;

    // opcodes
    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_TAP   = 2'd1;
    localparam logic [OP_W-1:0] OP_ADV   = 2'd2;

    // tap beat leaving the read stage
    typedef struct packed {
        logic valid;
        logic odd_first;
    } t_rd_stage;

endpackage

// File: rtl/fractional_delay_line.sv
// Fractional delay line with linearly interpolated taps.
// Input channel: i_valid / o_stall with i_opcode and its fields. A beat is taken
// on a rising edge with i_valid high and o_stall low. Opcode write stores i_sample
// at write pointer + i_block_pos; tap reads at write pointer + i_block_pos minus
// i_delay_offset (10.16 fixed point, wrapping) and yields one result; advance
// moves the write pointer by i_advance_count. Opcode 3 is ignored.
// Output channel: o_valid / i_stall with o_tap_value, one beat per tap.
// Throughput: one beat per cycle of any opcode while o_stall is low. The samples
// live in two banks (even and odd addresses), so both neighbors of a tap are read
// in the same cycle. A tap passes the bank read, difference, multiply and round
// registers in that order before it shows on o_valid.
// Reset clears the pointer and the pipeline, then a clearing pass writes zero to
// both banks one row per cycle through all DEPTH/2 rows, with o_stall held high.
// When the receiver stalls, the result is held and the pipeline keeps filling its
// empty stages; after clearing, o_stall rises only when every stage holds a tap.
module fractional_delay_line
    import fdl_pkg::*;
#(
    parameter int DEPTH       = DEF_DEPTH,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [OP_W-1:0]               i_opcode,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic [BPOS_W-1:0]             i_block_pos,
    input  logic [DELAY_W-1:0]            i_delay_offset,
    input  logic [ADV_W-1:0]              i_advance_count,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [SAMPLE_BITS-1:0] o_tap_value
);

    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = AW - 1;
    localparam int ROWS  = DEPTH / 2;
    localparam int POS_W = AW + FRAC_BITS;
    localparam int SUB_W = (POS_W > DELAY_W) ? POS_W : DELAY_W;
    localparam int BW    = (AW > BPOS_W) ? AW : BPOS_W;
    localparam int VW    = (AW > ADV_W) ? AW : ADV_W;

    logic [AW-1:0]          r_wr_pos;
    logic                   r_clearing;
    logic [RW-1:0]          r_clr_row;
    t_rd_stage              r_rd;
    logic [FRAC_BITS-1:0]   r_rd_frac;

    logic                   accept;
    logic                   take;
    logic                   en1;
    logic [BW-1:0]          base_sum;
    logic [AW-1:0]          base;
    logic [VW-1:0]          adv_sum;
    logic [SUB_W-1:0]       pos_diff;
    logic [POS_W-1:0]       pos;
    logic [AW-1:0]          ip;
    logic [RW-1:0]          even_rd;
    logic                   wr_hit;
    logic                   even_we;
    logic                   odd_we;
    logic [RW-1:0]          wr_row;
    logic [SAMPLE_BITS-1:0] wr_data;
    logic [SAMPLE_BITS-1:0] even_data;
    logic [SAMPLE_BITS-1:0] odd_data;

    // handshake
    assign en1     = !r_rd.valid || take;
    assign o_stall = r_clearing || !en1;
    assign accept  = i_valid && !o_stall;

    // address arithmetic
    assign base_sum = BW'(r_wr_pos) + BW'(i_block_pos);
    assign base     = base_sum[AW-1:0];
    assign adv_sum  = VW'(r_wr_pos) + VW'(i_advance_count);
    assign pos_diff = (SUB_W'(base) << FRAC_BITS) - SUB_W'(i_delay_offset);
    assign pos      = pos_diff[POS_W-1:0];
    assign ip       = pos[POS_W-1:FRAC_BITS];
    // odd bank row is ip/2; the even neighbor sits one row on when ip is odd
    assign even_rd  = ip[AW-1:1] + RW'(ip[0]);

    // bank writes: clearing pass or write beat
    assign wr_hit  = accept && (i_opcode == OP_WRITE);
    assign even_we = r_clearing || (wr_hit && !base[0]);
    assign odd_we  = r_clearing || (wr_hit && base[0]);
    assign wr_row  = r_clearing ? r_clr_row : base[AW-1:1];
    assign wr_data = r_clearing ? '0 : i_sample;

    // write pointer and clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_pos   <= '0;
            r_clearing <= 1'b1;
            r_clr_row  <= '0;
        end else begin
            if (accept && (i_opcode == OP_ADV)) begin
                r_wr_pos <= adv_sum[AW-1:0];
            end
            if (r_clearing) begin
                r_clr_row <= r_clr_row + RW'(1);
                if (r_clr_row == '1) begin
                    r_clearing <= 1'b0;
                end
            end
        end
    end

    // read stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd <= '0;
        end else if (en1) begin
            r_rd.valid     <= accept && (i_opcode == OP_TAP);
            r_rd.odd_first <= ip[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_rd_frac <= pos[FRAC_BITS-1:0];
        end
    end

    fdl_bank #(
        .ROWS  (ROWS),
        .WIDTH (SAMPLE_BITS)
    ) u_even (
        .i_clk     (i_clk),
        .i_we      (even_we),
        .i_wr_addr (wr_row),
        .i_wr_data (wr_data),
        .i_rd_en   (en1),
        .i_rd_addr (even_rd),
        .o_rd_data (even_data)
    );

    fdl_bank #(
        .ROWS  (ROWS),
        .WIDTH (SAMPLE_BITS)
    ) u_odd (
        .i_clk     (i_clk),
        .i_we      (odd_we),
        .i_wr_addr (wr_row),
        .i_wr_data (wr_data),
        .i_rd_en   (en1),
        .i_rd_addr (ip[AW-1:1]),
        .o_rd_data (odd_data)
    );

    fdl_interp #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_interp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd        (r_rd),
        .i_frac      (r_rd_frac),
        .i_even      (even_data),
        .i_odd       (odd_data),
        .o_take      (take),
        .o_valid     (o_valid),
        .o_tap_value (o_tap_value),
        .i_stall     (i_stall)
    );

    // no result can appear before the banks are cleared
    a_clr_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !o_valid && !r_rd.valid)
        else $error("tap in flight during clearing pass");

    // pointer moves only on an accepted advance beat
    a_ptr_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(accept && (i_opcode == OP_ADV)) |=> $stable(r_wr_pos))
        else $error("write pointer moved without advance");

    // a held read stage keeps its bank data
    a_rd_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd.valid && !take |=> r_rd.valid && $stable(even_data) && $stable(odd_data))
        else $error("bank read data lost under stall");

endmodule

// File: rtl/fdl_bank.sv
module fdl_bank
    import fdl_pkg::*;
#(
    parameter int ROWS  = DEF_DEPTH / 2,
    parameter int WIDTH = DEF_SAMPLE_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(ROWS)-1:0]  i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(ROWS)-1:0]  i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [ROWS];
    logic [WIDTH-1:0] r_rd_data;

    // single write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/fdl_interp.sv
module fdl_interp
    import fdl_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_rd_stage                     i_rd,
    input  logic [FRAC_BITS-1:0]          i_frac,
    input  logic [SAMPLE_BITS-1:0]        i_even,
    input  logic [SAMPLE_BITS-1:0]        i_odd,
    output logic                          o_take,
    output logic                          o_valid,
    output logic signed [SAMPLE_BITS-1:0] o_tap_value,
    input  logic                          i_stall
);

    localparam int PW = SAMPLE_BITS + FRAC_BITS + 2;
    localparam logic [PW-1:0] HALF = {{(PW-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);

    logic                          r_s2_valid;
    logic signed [SAMPLE_BITS-1:0] r_s2_a;
    logic signed [SAMPLE_BITS:0]   r_s2_diff;
    logic [FRAC_BITS-1:0]          r_s2_frac;
    logic                          r_s3_valid;
    logic signed [SAMPLE_BITS-1:0] r_s3_a;
    logic signed [PW-1:0]          r_s3_prod;
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out;

    logic                          en3;
    logic                          en4;
    logic signed [SAMPLE_BITS-1:0] smp_a;
    logic signed [SAMPLE_BITS-1:0] smp_b;
    logic signed [SAMPLE_BITS:0]   n_diff;
    logic signed [PW-1:0]          n_prod;
    logic signed [PW-1:0]          rounded;
    logic signed [PW-1:0]          n_sum;

    // stage enables, each stage moves when its successor has room
    assign en4    = !r_out_valid || !i_stall;
    assign en3    = !r_s3_valid || en4;
    assign o_take = !r_s2_valid || en3;

    // pick the sample at the integer position and its neighbor
    assign smp_a  = i_rd.odd_first ? $signed(i_odd) : $signed(i_even);
    assign smp_b  = i_rd.odd_first ? $signed(i_even) : $signed(i_odd);
    assign n_diff = {smp_b[SAMPLE_BITS-1], smp_b} - {smp_a[SAMPLE_BITS-1], smp_a};

    // slope times fraction
    assign n_prod = r_s2_diff * $signed({1'b0, r_s2_frac});

    // round half up, floor shift, add base sample
    assign rounded = (r_s3_prod + $signed(HALF)) >>> FRAC_BITS;
    assign n_sum   = rounded + {{(PW-SAMPLE_BITS){r_s3_a[SAMPLE_BITS-1]}}, r_s3_a};

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_take) begin
                r_s2_valid <= i_rd.valid;
            end
            if (en3) begin
                r_s3_valid <= r_s2_valid;
            end
            if (en4) begin
                r_out_valid <= r_s3_valid;
            end
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_s2_a    <= smp_a;
            r_s2_diff <= n_diff;
            r_s2_frac <= i_frac;
        end
        if (en3) begin
            r_s3_a    <= r_s2_a;
            r_s3_prod <= n_prod;
        end
        if (en4) begin
            r_out <= n_sum[SAMPLE_BITS-1:0];
        end
    end

    assign o_valid     = r_out_valid;
    assign o_tap_value = r_out;

    // a stalled multiply stage keeps its beat
    a_s3_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s3_valid && !en3 |=> r_s3_valid && $stable(r_s3_prod))
        else $error("multiply stage lost a beat under stall");

    // a stalled result is not overwritten
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_stall |=> r_out_valid && $stable(r_out))
        else $error("pending result overwritten");

endmodule
